/* src/bsad_pkg.sv */
package bsad_pkg;

    // Result region codes
    typedef enum logic [3:0] {
        REGION_BOOT     = 4'd0,
        REGION_ROM      = 4'd1,
        REGION_EXTRAM   = 4'd2,
        REGION_INTERNAL = 4'd3,
        REGION_SCROLLY  = 4'd4,
        REGION_SCROLLX  = 4'd5,
        REGION_LINE     = 4'd6,
        REGION_BANKCTL  = 4'd7,
        REGION_DROPPED  = 4'd8
    } region_t;

    // Controller kinds
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MBC1 = 2'd1,
        KIND_MBC2 = 2'd2,
        KIND_RSVD = 2'd3
    } ctl_kind_t;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Bank-control windows, address bits 14:13 below 0x8000
    typedef enum logic [1:0] {
        WIN_RAM_EN  = 2'd0,
        WIN_ROM_LO  = 2'd1,
        WIN_UPPER   = 2'd2,
        WIN_MODE    = 2'd3
    } bank_win_t;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned OFFSET_W = 21;
    localparam int unsigned ROMB_W   = 7;
    localparam int unsigned RAMB_W   = 2;

    localparam logic [ADDR_W-1:0] ADDR_BOOT_END  = 16'h00FF;
    localparam logic [ADDR_W-1:0] ADDR_ROMX_LO   = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM_LO   = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_EXT_LO    = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_EXT_HI    = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_ECHO_LO   = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_ECHO_HI   = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_DROP_LO   = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_DROP_HI   = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_SCROLLY   = 16'hFF42;
    localparam logic [ADDR_W-1:0] ADDR_SCROLLX   = 16'hFF43;
    localparam logic [ADDR_W-1:0] ADDR_LINE      = 16'hFF44;

    localparam logic [3:0] RAM_EN_KEY  = 4'hA;
    localparam logic [3:0] RAM_DIS_KEY = 4'h0;

    function automatic region_t io_region(input logic [ADDR_W-1:0] addr);
        region_t r;
        r = REGION_INTERNAL;
        if (addr == ADDR_SCROLLY)
        begin
            r = REGION_SCROLLY;
        end
        else if (addr == ADDR_SCROLLX)
        begin
            r = REGION_SCROLLX;
        end
        else if (addr == ADDR_LINE)
        begin
            r = REGION_LINE;
        end
        return r;
    endfunction

endpackage

/* src/bank_switch_address_decoder_unit.sv */
// Path from input word accepted to result word valid: input register, then result register.
// Throughput: one word per cycle; the result register is the only thing that can stall the input.
// Bank state is updated as a word moves from the input register to the result register,
// so each word sees the state left by the word before it.
// Reset (rst_n low, asynchronous): pipeline empty, controller kind none, ROM bank 1,
// RAM bank 0, RAM disabled, ROM banking mode.
module bank_switch_address_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: controller kind
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    // input bus access stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_tuser,   // [0] cmd (0 read, 1 write)
    // decoded result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [20:0] target_offset, [21] echo_mirror,
                                   // [28:22] rom_bank_now, [30:29] ram_bank_now,
                                   // [31] ram_enable_now
    output logic [3:0]  m_tuser    // [3:0] region
);
    import bsad_pkg::*;

    // ---------------- configuration ----------------
    ctl_kind_t kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
        end
        else if (cfg_wr_en)
        begin
            kind_reg <= ctl_kind_t'(cfg_wr_data);
        end
    end

    // ---------------- input register ----------------
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              advance;

    // stage 1 moves into the result register when the latter is free or being drained
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    // ---------------- bank state ----------------
    logic [ROMB_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAMB_W-1:0] ram_bank_reg, ram_bank_next;
    logic              ram_en_reg,   ram_en_next;
    logic              ram_mode_reg, ram_mode_next;

    logic is_mbc1, is_mbc2;
    logic [ROMB_W-1:0] rom_cand_lo, rom_cand_hi;

    assign is_mbc1 = (kind_reg == KIND_MBC1);
    assign is_mbc2 = (kind_reg == KIND_MBC2);

    // bank zero alone maps to one; 0x20/0x40/0x60 stay as written
    assign rom_cand_lo = {rom_bank_reg[6:5], in_data_reg[4:0]};
    assign rom_cand_hi = {in_data_reg[1:0], rom_bank_reg[4:0]};

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        ram_en_next   = ram_en_reg;
        ram_mode_next = ram_mode_reg;
        if (in_cmd_reg == CMD_WRITE && !in_addr_reg[15])
        begin
            unique case (bank_win_t'(in_addr_reg[14:13]))
                WIN_RAM_EN:
                begin
                    // MBC2 ignores this window when address bit 8 is set
                    if ((is_mbc1 || is_mbc2) && !(is_mbc2 && in_addr_reg[8]))
                    begin
                        if (in_data_reg[3:0] == RAM_EN_KEY)
                        begin
                            ram_en_next = 1'b1;
                        end
                        else if (in_data_reg[3:0] == RAM_DIS_KEY)
                        begin
                            ram_en_next = 1'b0;
                        end
                    end
                end
                WIN_ROM_LO:
                begin
                    if (is_mbc1 || is_mbc2)
                    begin
                        rom_bank_next = (rom_cand_lo == '0) ? ROMB_W'(1) : rom_cand_lo;
                    end
                end
                WIN_UPPER:
                begin
                    if (is_mbc1)
                    begin
                        if (ram_mode_reg)
                        begin
                            ram_bank_next = in_data_reg[1:0];
                        end
                        else
                        begin
                            rom_bank_next = (rom_cand_hi == '0) ? ROMB_W'(1) : rom_cand_hi;
                        end
                    end
                end
                WIN_MODE:
                begin
                    if (is_mbc1)
                    begin
                        ram_mode_next = in_data_reg[0];
                        if (!in_data_reg[0])
                        begin
                            ram_bank_next = '0;
                        end
                    end
                end
                default:
                begin
                    rom_bank_next = rom_bank_reg;
                end
            endcase
        end
    end

    // ---------------- address decode ----------------
    region_t             region_next;
    logic [OFFSET_W-1:0] offset_next;
    logic                echo_next;

    always_comb
    begin
        region_next = REGION_INTERNAL;
        offset_next = OFFSET_W'(in_addr_reg);
        echo_next   = 1'b0;
        if (in_cmd_reg == CMD_READ)
        begin
            priority if (in_addr_reg <= ADDR_BOOT_END)
            begin
                region_next = REGION_BOOT;
            end
            else if (in_addr_reg >= ADDR_ROMX_LO && in_addr_reg < ADDR_VRAM_LO)
            begin
                // switchable ROM: bank number on top of the 16 KiB offset
                region_next = REGION_ROM;
                offset_next = {rom_bank_reg, in_addr_reg[13:0]};
            end
            else if (in_addr_reg >= ADDR_EXT_LO && in_addr_reg < ADDR_EXT_HI)
            begin
                // external RAM: 8 KiB banks
                region_next = REGION_EXTRAM;
                offset_next = OFFSET_W'({ram_bank_reg, in_addr_reg[12:0]});
            end
            else
            begin
                region_next = io_region(in_addr_reg);
            end
        end
        else
        begin
            priority if (in_addr_reg < ADDR_VRAM_LO)
            begin
                region_next = REGION_BANKCTL;
            end
            else if (in_addr_reg >= ADDR_ECHO_LO && in_addr_reg < ADDR_ECHO_HI)
            begin
                region_next = REGION_INTERNAL;
                echo_next   = 1'b1;
            end
            else if (in_addr_reg >= ADDR_DROP_LO && in_addr_reg < ADDR_DROP_HI)
            begin
                region_next = REGION_DROPPED;
                offset_next = '0;
            end
            else
            begin
                region_next = io_region(in_addr_reg);
            end
        end
        // video registers carry no offset
        if (region_next == REGION_SCROLLY || region_next == REGION_SCROLLX ||
            region_next == REGION_LINE)
        begin
            offset_next = '0;
        end
    end

    // ---------------- state update and result register ----------------
    logic                out_valid_reg;
    region_t             out_region_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_echo_reg;
    logic [ROMB_W-1:0]   out_rom_reg;
    logic [RAMB_W-1:0]   out_ram_reg;
    logic                out_ram_en_reg;
    logic                fire;

    assign fire = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg  <= ROMB_W'(1);
            ram_bank_reg  <= '0;
            ram_en_reg    <= 1'b0;
            ram_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                rom_bank_reg <= rom_bank_next;
                ram_bank_reg <= ram_bank_next;
                ram_en_reg   <= ram_en_next;
                ram_mode_reg <= ram_mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_region_reg <= region_next;
            out_offset_reg <= offset_next;
            out_echo_reg   <= echo_next;
            out_rom_reg    <= rom_bank_next;
            out_ram_reg    <= ram_bank_next;
            out_ram_en_reg <= ram_en_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_region_reg;
    assign m_tdata  = {out_ram_en_reg, out_ram_reg, out_rom_reg, out_echo_reg, out_offset_reg};

endmodule

/* tb/sv/tb_bank_switch_address_decoder_unit.sv */
module tb_bank_switch_address_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bsad_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    // one decoded access as it should leave the block
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;      // for messages only, not on the bus
        region_t             region;
        logic [OFFSET_W-1:0] offset;
        logic                echo;
        logic [ROMB_W-1:0]   rom_bank;
        logic [RAMB_W-1:0]   ram_bank;
        logic                ram_on;
    } decode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] address, [23:16] write_data
    logic        s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [20:0] offset, [21] echo, [28:22] rom bank,
                            // [30:29] ram bank, [31] ram enable
    logic [3:0]  m_tuser;   // [3:0] region

    // bank controller shadow
    ctl_kind_t         cur_kind;
    logic [ROMB_W-1:0] rom_bank;
    logic [RAMB_W-1:0] ram_bank;
    logic              ram_on;
    logic              ram_mode;

    decode_t     pending_decodes[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_gap_max = 13;
    int unsigned sink_gap_max = 13;
    int unsigned sink_stall = 0;
    int unsigned sink_hold = 0;

    // region edges; random traffic lands on and around these
    logic [ADDR_W-1:0] boundary_addrs [14] = '{
        16'h0000, 16'h0100, 16'h2000, ADDR_ROMX_LO, 16'h6000, ADDR_VRAM_LO, ADDR_EXT_LO,
        ADDR_EXT_HI, ADDR_ECHO_LO, ADDR_ECHO_HI, ADDR_DROP_LO, ADDR_DROP_HI, ADDR_SCROLLY,
        ADDR_LINE
    };

    bank_switch_address_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic region_t io_decode(input logic [ADDR_W-1:0] addr);
        region_t r;
        r = REGION_INTERNAL;
        if (addr == ADDR_SCROLLY)
        begin
            r = REGION_SCROLLY;
        end
        else if (addr == ADDR_SCROLLX)
        begin
            r = REGION_SCROLLX;
        end
        else if (addr == ADDR_LINE)
        begin
            r = REGION_LINE;
        end
        return r;
    endfunction

    // Decodes one access and advances the bank shadow; result carries the state after it.
    function automatic decode_t decode_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] data);
        decode_t   d;
        bank_win_t win;
        logic      mbc1;
        logic      mbc2;
        d.addr   = addr;
        d.region = REGION_INTERNAL;
        d.offset = OFFSET_W'(addr);
        d.echo   = 1'b0;
        mbc1     = (cur_kind == KIND_MBC1);
        mbc2     = (cur_kind == KIND_MBC2);
        if (cmd == CMD_READ)
        begin
            if (addr <= ADDR_BOOT_END)
            begin
                d.region = REGION_BOOT;
            end
            else if (addr >= ADDR_ROMX_LO && addr < ADDR_VRAM_LO)
            begin
                d.region = REGION_ROM;
                d.offset = {rom_bank, addr[13:0]};
            end
            else if (addr >= ADDR_EXT_LO && addr < ADDR_EXT_HI)
            begin
                d.region = REGION_EXTRAM;
                d.offset = OFFSET_W'({ram_bank, addr[12:0]});
            end
            else
            begin
                d.region = io_decode(addr);
            end
        end
        else
        begin
            if (addr < ADDR_VRAM_LO)
            begin
                d.region = REGION_BANKCTL;
                win = bank_win_t'(addr[14:13]);
                case (win)
                    WIN_RAM_EN:
                    begin
                        // MBC2 ignores enable writes with address bit 8 set
                        if ((mbc1 || mbc2) && !(mbc2 && addr[8]))
                        begin
                            if (data[3:0] == RAM_EN_KEY)
                            begin
                                ram_on = 1'b1;
                            end
                            else if (data[3:0] == RAM_DIS_KEY)
                            begin
                                ram_on = 1'b0;
                            end
                        end
                    end
                    WIN_ROM_LO:
                    begin
                        if (mbc1 || mbc2)
                        begin
                            rom_bank = {rom_bank[6:5], data[4:0]};
                            if (rom_bank == '0)
                            begin
                                rom_bank = 7'd1;
                            end
                        end
                    end
                    WIN_UPPER:
                    begin
                        if (mbc1 && ram_mode)
                        begin
                            ram_bank = data[1:0];
                        end
                        else if (mbc1)
                        begin
                            rom_bank = {data[1:0], rom_bank[4:0]};
                            if (rom_bank == '0)
                            begin
                                rom_bank = 7'd1;
                            end
                        end
                    end
                    default:
                    begin
                        if (mbc1)
                        begin
                            ram_mode = data[0];
                            if (!ram_mode)
                            begin
                                ram_bank = '0;
                            end
                        end
                    end
                endcase
            end
            else if (addr >= ADDR_ECHO_LO && addr < ADDR_ECHO_HI)
            begin
                d.echo = 1'b1;
            end
            else if (addr >= ADDR_DROP_LO && addr < ADDR_DROP_HI)
            begin
                d.region = REGION_DROPPED;
                d.offset = '0;
            end
            else
            begin
                d.region = io_decode(addr);
            end
        end
        if (d.region == REGION_SCROLLY || d.region == REGION_SCROLLX || d.region == REGION_LINE)
        begin
            d.offset = '0;
        end
        d.rom_bank = rom_bank;
        d.ram_bank = ram_bank;
        d.ram_on   = ram_on;
        return d;
    endfunction

    // Random access, mostly bank programming and banked reads so the banking state moves.
    function automatic void draw_access(output logic cmd, output logic [ADDR_W-1:0] addr,
                                        output logic [DATA_W-1:0] data);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        cmd  = 1'($urandom);
        addr = ADDR_W'($urandom);
        data = DATA_W'($urandom);
        if (pick < 25)
        begin
            cmd      = CMD_WRITE;
            addr[15] = 1'b0;
            case ($urandom_range(0, 3))
                0: data[3:0] = RAM_EN_KEY;
                1: data[3:0] = RAM_DIS_KEY;
                2: data[4:0] = 5'd0;
                default: ;
            endcase
        end
        else if (pick < 50)
        begin
            cmd = CMD_READ;
            if ($urandom_range(0, 1) == 0)
            begin
                addr[15:14] = 2'b01;
            end
            else
            begin
                addr[15:13] = 3'b101;
            end
        end
        else if (pick < 60)
        begin
            addr = 16'hFF40 + ADDR_W'($urandom_range(0, 7));
        end
        else if (pick < 70)
        begin
            addr = boundary_addrs[$urandom_range(0, 13)] + ADDR_W'($urandom_range(0, 2)) - 16'd1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] addr,
                                   input int unsigned got, input int unsigned want);
        $display("%0t: mismatch %s at address 0x%04h: got 0x%0h, expected 0x%0h",
                 $time, what, addr, got, want);
        mismatch_count++;
    endtask

    // Offer one word after a random gap and wait for the handshake.
    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata  = 24'($urandom);
            s_tuser  = 1'($urandom);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        pending_decodes.push_back(decode_access(cmd, addr, data));
    endtask

    task automatic drain_pipe();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Controller kind only changes with the pipe empty.
    task automatic program_kind(input ctl_kind_t kind);
        drain_pipe();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = kind;
        cur_kind    = kind;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // No controller: bank writes decode as bankctl but leave bank 1 in place.
    task automatic test_reset_state();
        send_access(CMD_WRITE, 16'h2000, 8'h00);
        send_access(CMD_WRITE, 16'h0000, 8'h0A);
        send_access(CMD_READ,  16'h4000, 8'hFF);
    endtask

    task automatic test_read_map();
        send_access(CMD_READ, 16'h0000, 8'h00);
        send_access(CMD_READ, ADDR_BOOT_END, 8'hFF);
        send_access(CMD_READ, 16'h0100, 8'h55);
        send_access(CMD_READ, 16'h7FFF, 8'hAA);
        send_access(CMD_READ, ADDR_EXT_LO, 8'h00);
        send_access(CMD_READ, 16'hBFFF, 8'h00);
        send_access(CMD_READ, ADDR_SCROLLY, 8'h00);
        send_access(CMD_READ, ADDR_SCROLLX, 8'h00);
        send_access(CMD_READ, ADDR_LINE, 8'h00);
        send_access(CMD_READ, 16'hFFFF, 8'hFF);
    endtask

    // Echo edges, dropped window edges, an io write.
    task automatic test_write_map();
        send_access(CMD_WRITE, ADDR_ECHO_LO, 8'h12);
        send_access(CMD_WRITE, 16'hFDFF, 8'h34);
        send_access(CMD_WRITE, ADDR_DROP_LO, 8'h56);
        send_access(CMD_WRITE, 16'hFEFF, 8'h78);
        send_access(CMD_WRITE, ADDR_LINE, 8'h9A);
    endtask

    task automatic test_mbc1_controls();
        program_kind(KIND_MBC1);
        send_access(CMD_WRITE, 16'h1FFF, 8'h3A);    // enable key in the low nibble
        send_access(CMD_WRITE, 16'h2000, 8'h00);    // bank zero maps to one
        send_access(CMD_WRITE, ADDR_ROMX_LO, 8'hFF); // upper ROM bits in ROM mode
        send_access(CMD_WRITE, 16'h3FFF, 8'hE0);    // bank 0x60 stays usable
        send_access(CMD_WRITE, 16'h6000, 8'h01);    // RAM banking mode
        send_access(CMD_WRITE, 16'h5FFF, 8'h02);
        send_access(CMD_READ,  16'hBFFF, 8'h00);
        send_access(CMD_WRITE, 16'h7FFF, 8'h00);    // back to ROM mode clears RAM bank
        send_access(CMD_WRITE, 16'h0000, 8'hF0);    // disable key
    endtask

    task automatic test_mbc2_controls();
        program_kind(KIND_MBC2);
        send_access(CMD_WRITE, 16'h0100, 8'h0A);    // address bit 8 set: ignored
        send_access(CMD_WRITE, 16'h00FF, 8'h0A);
        send_access(CMD_WRITE, ADDR_ROMX_LO, 8'h03); // no upper bits on MBC2
        send_access(CMD_WRITE, 16'h2000, 8'h1F);
        program_kind(KIND_RSVD);
        send_access(CMD_WRITE, 16'h2000, 8'h05);    // unused kind acts as none
    endtask

    // Random phases over every controller kind; idle limits change every hundred words.
    task automatic test_random_traffic();
        ctl_kind_t         kinds [5] = '{KIND_MBC1, KIND_MBC2, KIND_NONE, KIND_RSVD, KIND_MBC1};
        int unsigned       counts [5] = '{600, 400, 200, 150, 550};
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        for (int p = 0; p < 5; p++)
        begin
            program_kind(kinds[p]);
            for (int unsigned i = 0; i < counts[p]; i++)
            begin
                if (i % 100 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: src_gap_max = 0;
                        1: src_gap_max = 3;
                        default: src_gap_max = 13;
                    endcase
                    case ($urandom_range(0, 2))
                        0: sink_gap_max = 0;
                        1: sink_gap_max = 3;
                        default: sink_gap_max = 13;
                    endcase
                end
                draw_access(cmd, addr, data);
                send_access(cmd, addr, data);
            end
        end
    endtask

    // Receiver holds off while the sender streams back to back; input must stall.
    task automatic test_backpressure();
        logic              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        program_kind(KIND_MBC1);
        src_gap_max  = 0;
        sink_gap_max = 13;
        @(posedge clk);
        sink_hold = 200;
        for (int i = 0; i < 40; i++)
        begin
            draw_access(cmd, addr, data);
            send_access(cmd, addr, data);
        end
        src_gap_max = 13;
    endtask

    // Receiver: random stall per word, plus the long hold when one is requested.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready = 1'b0;
                sink_hold--;
            end
            else if (sink_stall > 0)
            begin
                m_tready = 1'b0;
                sink_stall--;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin : check_words
        decode_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_decodes.size() == 0)
            begin
                report_mismatch("unexpected word", '0, m_tdata, 0);
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (m_tuser != want.region)
                begin
                    report_mismatch("region", want.addr, m_tuser, want.region);
                end
                if (m_tdata[20:0] != want.offset)
                begin
                    report_mismatch("target offset", want.addr, m_tdata[20:0], want.offset);
                end
                if (m_tdata[21] != want.echo)
                begin
                    report_mismatch("echo mirror", want.addr, m_tdata[21], want.echo);
                end
                if (m_tdata[28:22] != want.rom_bank)
                begin
                    report_mismatch("rom bank", want.addr, m_tdata[28:22], want.rom_bank);
                end
                if (m_tdata[30:29] != want.ram_bank)
                begin
                    report_mismatch("ram bank", want.addr, m_tdata[30:29], want.ram_bank);
                end
                if (m_tdata[31] != want.ram_on)
                begin
                    report_mismatch("ram enable", want.addr, m_tdata[31], want.ram_on);
                end
            end
            sink_stall = $urandom_range(0, sink_gap_max);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_bank_switch_address_decoder_unit failed");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = KIND_NONE;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_READ;
        cur_kind    = KIND_NONE;
        rom_bank    = 7'd1;
        ram_bank    = '0;
        ram_on      = 1'b0;
        ram_mode    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_read_map();
        test_write_map();
        test_mbc1_controls();
        test_mbc2_controls();
        test_random_traffic();
        test_backpressure();

        drain_pipe();
        repeat (8) @(posedge clk);    // catch any stray word past the last one
        if (mismatch_count == 0)
        begin
            $display("tb_bank_switch_address_decoder_unit passed");
        end
        else
        begin
            $display("tb_bank_switch_address_decoder_unit failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/bsad_pkg.sv
src/bank_switch_address_decoder_unit.sv
tb/sv/tb_bank_switch_address_decoder_unit.sv
